// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dcf decoder: same-cycle assertion failed");
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dcf decoder: next-cycle assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post)
`define ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/dcf_pkg.sv -----
// Types, codes and helper functions of the DCF77 time code decoder.
// No dependencies; used by the result interface and all decoder modules.
package dcf_pkg;

    typedef logic [2:0] t_event;

    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_SECOND  = 3'd1;
    localparam t_event EV_MINUTE  = 3'd2;
    localparam t_event EV_ZERO    = 3'd3;
    localparam t_event EV_ONE     = 3'd4;
    localparam t_event EV_INVALID = 3'd5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_ZERO_LO   = 3'd0;
    localparam logic [2:0] REG_ZERO_HI   = 3'd1;
    localparam logic [2:0] REG_ONE_LO    = 3'd2;
    localparam logic [2:0] REG_ONE_HI    = 3'd3;
    localparam logic [2:0] REG_PERIOD_TOL = 3'd4;
    localparam logic [2:0] REG_ZONE_EN   = 3'd5;
    localparam logic [2:0] REG_HOUR_OFS  = 3'd6;

    localparam int APB_AW = 5;

    localparam logic [11:0] YEAR_BASE   = 12'd2000;
    localparam logic [5:0]  FRAME_LAST  = 6'd59;
    localparam logic [5:0]  SEC_MAX     = 6'd63;
    localparam logic [4:0]  HOURS_DAY   = 5'd24;

    typedef struct packed {
        logic [15:0] zero_lo;
        logic [15:0] zero_hi;
        logic [15:0] one_lo;
        logic [15:0] one_hi;
        logic [9:0]  period_tol;
        logic        zone_en;
        logic [4:0]  hour_ofs;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [3:0]  month;
        logic [11:0] year;
    } t_time;

    typedef struct packed {
        logic  ok;
        t_time tm;
    } t_frame;

    // two BCD digits to binary: low nibble + 10 * high nibble
    function automatic logic [7:0] bcd_value(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m) inside
            4'd2:                   d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ----- hdl/dcf_in_if.sv -----
// Sample channel: receiver level and millisecond timestamp per word.
// Depends on nothing.
interface dcf_in_if #(
    parameter int TW = 16
) ();
    logic          valid;
    logic          ready;
    logic          level;
    logic [TW-1:0] now_ms;

    modport source(output valid, level, now_ms, input ready);
    modport sink(input valid, level, now_ms, output ready);
endinterface

// ----- hdl/dcf_out_if.sv -----
// Result channel: event, frame status and decoded time per word.
// Depends on dcf_pkg for the event type.
interface dcf_out_if ();
    import dcf_pkg::*;

    logic        valid;
    logic        ready;
    t_event      event_code;
    logic        frame_done;
    logic        frame_ok;
    logic [6:0]  out_minute;
    logic [4:0]  out_hour;
    logic [4:0]  out_day;
    logic [2:0]  out_weekday;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic [5:0]  second_index;
    logic        sync_flag;
    logic        error_flag;

    modport source(output valid, event_code, frame_done, frame_ok, out_minute, out_hour,
                   out_day, out_weekday, out_month, out_year, second_index, sync_flag,
                   error_flag, input ready);
    modport sink(input valid, event_code, frame_done, frame_ok, out_minute, out_hour,
                 out_day, out_weekday, out_month, out_year, second_index, sync_flag,
                 error_flag, output ready);
endinterface

// ----- hdl/dcf_apb_regs.sv -----
// APB configuration registers of the decoder (pulse windows, zone shift).
// Depends on dcf_pkg.
module dcf_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output dcf_pkg::t_cfg               o_cfg
);
    import dcf_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_lo    <= 16'd70;
            r_cfg.zero_hi    <= 16'd130;
            r_cfg.one_lo     <= 16'd170;
            r_cfg.one_hi     <= 16'd230;
            r_cfg.period_tol <= 10'd100;
            r_cfg.zone_en    <= 1'b0;
            r_cfg.hour_ofs   <= 5'd6;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ZERO_LO:    r_cfg.zero_lo    <= pwdata[15:0];
                REG_ZERO_HI:    r_cfg.zero_hi    <= pwdata[15:0];
                REG_ONE_LO:     r_cfg.one_lo     <= pwdata[15:0];
                REG_ONE_HI:     r_cfg.one_hi     <= pwdata[15:0];
                REG_PERIOD_TOL: r_cfg.period_tol <= pwdata[9:0];
                REG_ZONE_EN:    r_cfg.zone_en    <= pwdata[0];
                REG_HOUR_OFS:   r_cfg.hour_ofs   <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ZERO_LO:    prdata = {16'd0, r_cfg.zero_lo};
            REG_ZERO_HI:    prdata = {16'd0, r_cfg.zero_hi};
            REG_ONE_LO:     prdata = {16'd0, r_cfg.one_lo};
            REG_ONE_HI:     prdata = {16'd0, r_cfg.one_hi};
            REG_PERIOD_TOL: prdata = {22'd0, r_cfg.period_tol};
            REG_ZONE_EN:    prdata = {31'd0, r_cfg.zone_en};
            REG_HOUR_OFS:   prdata = {27'd0, r_cfg.hour_ofs};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/dcf_pulse_class.sv -----
// Edge classifier: falling-edge spacing and low-pulse width to an event code.
// Depends on dcf_pkg.
module dcf_pulse_class #(
    parameter int TW = 16
) (
    input  dcf_pkg::t_cfg   i_cfg,
    input  logic            i_level,
    input  logic            i_last_level,
    input  logic [TW-1:0]   i_now,
    input  logic [TW-1:0]   i_fall_stamp,
    output dcf_pkg::t_event o_event
);
    import dcf_pkg::*;

    localparam int CW = TW + 1;

    logic [TW-1:0] diff;
    logic [CW-1:0] diff_x, lo_sum, tol_x;
    logic          near_sec, near_min, is_zero, is_one;

    // modulo-2^TW distance since the last falling edge
    assign diff   = i_now - i_fall_stamp;
    assign diff_x = {1'b0, diff};
    assign tol_x  = CW'(i_cfg.period_tol);
    assign lo_sum = diff_x + tol_x;

    assign near_sec = (lo_sum >= CW'(1000)) && (diff_x <= CW'(1000) + tol_x);
    assign near_min = (lo_sum >= CW'(2000)) && (diff_x <= CW'(2000) + tol_x);

    assign is_zero = (32'(diff) >= 32'(i_cfg.zero_lo)) && (32'(diff) <= 32'(i_cfg.zero_hi));
    assign is_one  = (32'(diff) >= 32'(i_cfg.one_lo))  && (32'(diff) <= 32'(i_cfg.one_hi));

    always_comb begin
        o_event = EV_NONE;
        if (i_last_level && !i_level) begin
            if (near_sec)      o_event = EV_SECOND;
            else if (near_min) o_event = EV_MINUTE;
            else               o_event = EV_INVALID;
        end else if (!i_last_level && i_level) begin
            if (is_zero)       o_event = EV_ZERO;
            else if (is_one)   o_event = EV_ONE;
            else               o_event = EV_INVALID;
        end
    end

endmodule

// ----- hdl/dcf_frame_dec.sv -----
// Frame decoder: BCD fields, parity and range checks, optional hour shift-back.
// Depends on dcf_pkg.
module dcf_frame_dec (
    input  dcf_pkg::t_cfg   i_cfg,
    input  logic [58:0]     i_bits,
    output dcf_pkg::t_frame o_frame
);
    import dcf_pkg::*;

    logic [7:0]  mi, hr, dy, mo, yr;
    logic [2:0]  wd;
    logic        par_ok, rng_ok, leap;
    logic [4:0]  ofs, hr5, dy5, hr_wrap;
    logic [3:0]  mo4, mo_prev;
    logic [11:0] year_full;
    logic        need_wrap;
    t_time       tm;

    assign mi = bcd_value({1'b0, i_bits[27:21]});
    assign hr = bcd_value({2'b0, i_bits[34:29]});
    assign dy = bcd_value({2'b0, i_bits[41:36]});
    assign wd = i_bits[44:42];
    assign mo = bcd_value({3'b0, i_bits[49:45]});
    assign yr = bcd_value(i_bits[57:50]);

    // even parity over each group, date group runs through bit 58
    assign par_ok = !(^i_bits[28:21]) && !(^i_bits[35:29]) && !(^i_bits[58:36]);
    assign rng_ok = (mi <= 8'd59) && (hr <= 8'd23) && (dy >= 8'd1) && (dy <= 8'd31)
                  && (mo >= 8'd1) && (mo <= 8'd12) && (wd != 3'd0);

    assign hr5       = hr[4:0];
    assign dy5       = dy[4:0];
    assign mo4       = mo[3:0];
    assign year_full = YEAR_BASE + 12'(yr);
    // Feb is only reached from March, so the year is the frame's own;
    // in 2000..2165 only 2100 breaks the every-fourth-year rule
    assign leap      = (yr[1:0] == 2'd0) && (yr != 8'd100);
    assign ofs       = (i_cfg.hour_ofs >= HOURS_DAY) ? i_cfg.hour_ofs - HOURS_DAY
                                                     : i_cfg.hour_ofs;
    assign need_wrap = hr5 < ofs;
    assign hr_wrap   = 5'(6'(hr5) + 6'(HOURS_DAY) - 6'(ofs));
    assign mo_prev   = (mo4 > 4'd1) ? mo4 - 4'd1 : 4'd12;

    always_comb begin
        tm.minute  = mi[6:0];
        tm.hour    = hr5;
        tm.day     = dy5;
        tm.weekday = wd;
        tm.month   = mo4;
        tm.year    = year_full;
        if (i_cfg.zone_en) begin
            if (!need_wrap) begin
                tm.hour = hr5 - ofs;
            end else begin
                tm.hour = hr_wrap;
                if (dy5 > 5'd1) begin
                    tm.day = dy5 - 5'd1;
                end else begin
                    tm.month = mo_prev;
                    if (mo4 <= 4'd1) tm.year = year_full - 12'd1;
                    tm.day = month_days(mo_prev, leap);
                end
            end
        end
    end

    assign o_frame.ok = par_ok & rng_ok;
    assign o_frame.tm = tm;

endmodule

// ----- hdl/dcf77_time_code_decoder.sv -----
// DCF77 time code decoder, top level. An accepted sample word moves from the input
// register into the result register once that one is empty or being taken. Throughput:
// one word per cycle while the result is not stalled, set by the input register feeding
// the result register through one pass of combinational logic; a stalled result holds
// the input register. Reset (synchronous, active low) clears both stage valids and loads
// decoder state and config with their reset values.
`include "assert_macros.svh"
module dcf77_time_code_decoder #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dcf_in_if.sink                      i_sample,
    dcf_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcf_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import dcf_pkg::*;

    // ---------------- configuration ----------------
    t_cfg cfg;

    dcf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- handshake ----------------
    // Input register takes a word whenever it is empty or moving on; it moves on
    // into the result register whenever that one is empty or being taken.
    logic                  r_s1_valid, r_o_valid;
    logic                  r_s1_level;
    logic [TIME_WIDTH-1:0] r_s1_now;
    logic                  in_acc, adv;

    assign adv            = r_s1_valid && (!r_o_valid || o_result.ready);
    assign i_sample.ready = !r_s1_valid || adv;
    assign in_acc         = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc)   r_s1_valid <= 1'b1;
            else if (adv) r_s1_valid <= 1'b0;
            if (adv)                  r_o_valid <= 1'b1;
            else if (o_result.ready)  r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_level <= i_sample.level;
            r_s1_now   <= i_sample.now_ms;
        end
    end

    // ---------------- decoder state ----------------
    logic                  r_last_level, n_last_level;
    logic [TIME_WIDTH-1:0] r_fall_stamp, n_fall_stamp;
    logic [58:0]           r_frame_bits, n_frame_bits;
    logic [5:0]            r_sec_cnt, n_sec_cnt;
    logic [6:0]            r_minute, n_minute;
    t_time                 r_time, n_time;
    logic                  r_sync, n_sync;
    logic                  r_error, n_error;

    t_event ev;
    t_frame frame;
    logic   done, ok;

    dcf_pulse_class #(
        .TW (TIME_WIDTH)
    ) u_class (
        .i_cfg        (cfg),
        .i_level      (r_s1_level),
        .i_last_level (r_last_level),
        .i_now        (r_s1_now),
        .i_fall_stamp (r_fall_stamp),
        .o_event      (ev)
    );

    dcf_frame_dec u_frame (
        .i_cfg   (cfg),
        .i_bits  (r_frame_bits),
        .o_frame (frame)
    );

    // next state for the word in the input register
    always_comb begin
        n_last_level = r_s1_level;
        n_fall_stamp = r_fall_stamp;
        n_frame_bits = r_frame_bits;
        n_sec_cnt    = r_sec_cnt;
        n_minute     = r_minute;
        n_time       = r_time;
        n_sync       = r_sync;
        n_error      = r_error;
        done         = 1'b0;
        ok           = 1'b0;

        if (r_last_level && !r_s1_level) n_fall_stamp = r_s1_now;

        case (ev)
            EV_SECOND: begin
                if (r_sec_cnt < SEC_MAX) n_sec_cnt = r_sec_cnt + 6'd1;
            end
            EV_ONE: begin
                // bits past the frame end are dropped
                if (r_sec_cnt < FRAME_LAST) n_frame_bits[r_sec_cnt] = 1'b1;
            end
            EV_MINUTE: begin
                done     = 1'b1;
                n_minute = frame.tm.minute;   // minute kept even from a bad frame
                if (frame.ok) begin
                    ok      = 1'b1;
                    n_time  = frame.tm;
                    n_sync  = 1'b1;
                    n_error = 1'b0;
                end else begin
                    n_sync  = 1'b0;
                    n_error = 1'b1;
                end
                n_sec_cnt    = 6'd0;
                n_frame_bits = '0;
            end
            EV_INVALID: begin
                n_sync  = 1'b0;
                n_error = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b0;
            r_fall_stamp   <= '0;
            r_frame_bits   <= '0;
            r_sec_cnt      <= 6'd0;
            r_minute       <= 7'd0;
            r_time.minute  <= 7'd0;
            r_time.hour    <= 5'd0;
            r_time.day     <= 5'd0;
            r_time.weekday <= 3'd1;
            r_time.month   <= 4'd0;
            r_time.year    <= YEAR_BASE;
            r_sync         <= 1'b0;
            r_error        <= 1'b0;
        end else if (adv) begin
            r_last_level <= n_last_level;
            r_fall_stamp <= n_fall_stamp;
            r_frame_bits <= n_frame_bits;
            r_sec_cnt    <= n_sec_cnt;
            r_minute     <= n_minute;
            r_time       <= n_time;
            r_sync       <= n_sync;
            r_error      <= n_error;
        end
    end

    // ---------------- result register ----------------
    t_event      r_o_event;
    logic        r_o_done, r_o_ok, r_o_sync, r_o_error;
    logic [6:0]  r_o_minute;
    t_time       r_o_time;
    logic [5:0]  r_o_sec;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_event  <= ev;
            r_o_done   <= done;
            r_o_ok     <= ok;
            r_o_minute <= n_minute;
            r_o_time   <= n_time;
            r_o_sec    <= n_sec_cnt;
            r_o_sync   <= n_sync;
            r_o_error  <= n_error;
        end
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.event_code   = r_o_event;
    assign o_result.frame_done   = r_o_done;
    assign o_result.frame_ok     = r_o_ok;
    assign o_result.out_minute   = r_o_minute;
    assign o_result.out_hour     = r_o_time.hour;
    assign o_result.out_day      = r_o_time.day;
    assign o_result.out_weekday  = r_o_time.weekday;
    assign o_result.out_month    = r_o_time.month;
    assign o_result.out_year     = r_o_time.year;
    assign o_result.second_index = r_o_sec;
    assign o_result.sync_flag    = r_o_sync;
    assign o_result.error_flag   = r_o_error;

    // ---------------- assertions ----------------
    logic minute_adv, frame_clear, locked;

    assign minute_adv  = adv && (ev == EV_MINUTE);
    assign frame_clear = (r_sec_cnt == 6'd0) && (r_frame_bits == '0);
    assign locked      = r_sync && !r_error && r_o_done;

    // a minute mark always restarts the frame
    `ASSERT_NEXT(a_minute_clears, i_clk, i_rst_n, minute_adv, frame_clear)
    // a good frame in the result word matches the locked state
    `ASSERT_IMPLIES(a_ok_means_sync, i_clk, i_rst_n, r_o_valid && r_o_ok, locked)
    // a word stuck in the input register stays put
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !adv, r_s1_valid && $stable(r_s1_now))

endmodule
